>>> design/udrb_pkg.sv
`default_nettype none

package udrb_pkg;

    // Ring sizes
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;

    // Index and fill counter widths
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    // Field widths of the item formats
    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LINE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TXRDY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // Line control characters
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_TX_FULL = 3'd1,
        ST_RX_EMPTY = 3'd2,
        ST_RX_DROP = 3'd3,
        ST_TX_IDLE = 3'd4
    } status_t;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_GET,
        OP_LINE,
        OP_TXRDY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   read_byte;
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                echo_lost;
        logic [FILL_W-1:0]   rx_fill;
        logic [FILL_W-1:0]   tx_fill;
        logic                cr_seen;
        logic                lf_seen;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              is_cr;
        logic              is_lf;
    } op_item_t;

endpackage

`default_nettype wire

>>> design/udrb_front.sv
`default_nettype none

module udrb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire udrb_pkg::in_item_t in_item,
    output logic                    q_valid,
    output udrb_pkg::op_item_t      q_item,
    input  wire logic               q_pop
);

    udrb_pkg::op_item_t q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    udrb_pkg::op_item_t dec;

    // Classify the incoming command
    always_comb
    begin
        dec.data  = in_item.data_byte;
        dec.is_cr = (in_item.data_byte == udrb_pkg::CH_CR);
        dec.is_lf = (in_item.data_byte == udrb_pkg::CH_LF);
        case (in_item.cmd)
            udrb_pkg::CMD_PUT:   dec.op = udrb_pkg::OP_PUT;
            udrb_pkg::CMD_GET:   dec.op = udrb_pkg::OP_GET;
            udrb_pkg::CMD_LINE:  dec.op = udrb_pkg::OP_LINE;
            udrb_pkg::CMD_TXRDY: dec.op = udrb_pkg::OP_TXRDY;
            udrb_pkg::CMD_CLEAR: dec.op = udrb_pkg::OP_CLEAR;
            default:             dec.op = udrb_pkg::OP_NONE;
        endcase
    end

    // Hold the input while both queue slots are taken
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    // Advance the queue pointers
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the decoded item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

>>> design/udrb_back.sv
`default_nettype none

module udrb_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               echo_en,
    input  wire logic               q_valid,
    input  wire udrb_pkg::op_item_t q_item,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output udrb_pkg::out_item_t     out_item
);

    logic [udrb_pkg::BYTE_W-1:0] tx_mem [udrb_pkg::TX_DEPTH];
    logic [udrb_pkg::BYTE_W-1:0] rx_mem [udrb_pkg::RX_DEPTH];

    logic [udrb_pkg::TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [udrb_pkg::TX_AW-1:0] tx_tail_reg, tx_tail_next;
    logic [udrb_pkg::TX_CW-1:0] tx_cnt_reg, tx_cnt_next;
    logic [udrb_pkg::RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [udrb_pkg::RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [udrb_pkg::RX_CW-1:0] rx_cnt_reg, rx_cnt_next;
    logic cr_reg, cr_next;
    logic lf_reg, lf_next;
    logic out_valid_reg, out_valid_next;

    // Result payload
    udrb_pkg::status_t           status_reg, status_next;
    logic [udrb_pkg::BYTE_W-1:0] read_byte_reg;
    logic [udrb_pkg::BYTE_W-1:0] tx_byte_reg;
    logic                        tx_valid_reg;
    logic                        lost_reg, lost_next;
    logic [udrb_pkg::FILL_W-1:0] rx_fill_reg;
    logic [udrb_pkg::FILL_W-1:0] tx_fill_reg;
    logic                        cr_seen_reg;
    logic                        lf_seen_reg;

    logic go;
    logic get_ok;
    logic tx_pop;
    logic tx_wr;
    logic tx_wr_echo;
    logic rx_wr;
    logic tx_full;
    logic [udrb_pkg::TX_AW-1:0] tx_head_inc;
    logic [udrb_pkg::TX_AW-1:0] tx_tail_inc;
    logic [udrb_pkg::RX_AW-1:0] rx_head_inc;
    logic [udrb_pkg::RX_AW-1:0] rx_tail_inc;

    // Take the next item when the result register is free or drains
    assign go    = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = go;

    assign tx_full = (tx_cnt_reg == udrb_pkg::TX_CW'(udrb_pkg::TX_DEPTH));

    // Wrapping index steps
    assign tx_head_inc = (tx_head_reg == udrb_pkg::TX_AW'(udrb_pkg::TX_DEPTH - 1)) ?
                         '0 : tx_head_reg + udrb_pkg::TX_AW'(1);
    assign tx_tail_inc = (tx_tail_reg == udrb_pkg::TX_AW'(udrb_pkg::TX_DEPTH - 1)) ?
                         '0 : tx_tail_reg + udrb_pkg::TX_AW'(1);
    assign rx_head_inc = (rx_head_reg == udrb_pkg::RX_AW'(udrb_pkg::RX_DEPTH - 1)) ?
                         '0 : rx_head_reg + udrb_pkg::RX_AW'(1);
    assign rx_tail_inc = (rx_tail_reg == udrb_pkg::RX_AW'(udrb_pkg::RX_DEPTH - 1)) ?
                         '0 : rx_tail_reg + udrb_pkg::RX_AW'(1);

    // Carry out one command on the rings
    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_cnt_next  = tx_cnt_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_cnt_next  = rx_cnt_reg;
        cr_next      = cr_reg;
        lf_next      = lf_reg;
        status_next  = udrb_pkg::ST_OK;
        lost_next    = 1'b0;
        get_ok       = 1'b0;
        tx_pop       = 1'b0;
        tx_wr        = 1'b0;
        tx_wr_echo   = 1'b0;
        rx_wr        = 1'b0;
        if (go)
        begin
            case (q_item.op)
                udrb_pkg::OP_PUT:
                begin
                    if (tx_full)
                    begin
                        status_next = udrb_pkg::ST_TX_FULL;
                    end
                    else
                    begin
                        tx_wr        = 1'b1;
                        tx_head_next = tx_head_inc;
                        tx_cnt_next  = tx_cnt_reg + udrb_pkg::TX_CW'(1);
                    end
                end
                udrb_pkg::OP_GET:
                begin
                    if (rx_cnt_reg == '0)
                    begin
                        status_next = udrb_pkg::ST_RX_EMPTY;
                    end
                    else
                    begin
                        get_ok       = 1'b1;
                        rx_tail_next = rx_tail_inc;
                        rx_cnt_next  = rx_cnt_reg - udrb_pkg::RX_CW'(1);
                        if (echo_en)
                        begin
                            if (tx_full)
                            begin
                                lost_next = 1'b1;
                            end
                            else
                            begin
                                tx_wr        = 1'b1;
                                tx_wr_echo   = 1'b1;
                                tx_head_next = tx_head_inc;
                                tx_cnt_next  = tx_cnt_reg + udrb_pkg::TX_CW'(1);
                            end
                        end
                    end
                end
                udrb_pkg::OP_LINE:
                begin
                    if (q_item.is_cr)
                    begin
                        cr_next = 1'b1;
                    end
                    if (q_item.is_lf)
                    begin
                        lf_next = 1'b1;
                    end
                    // Drop the byte when the write index would meet the read index
                    if (rx_head_inc != rx_tail_reg)
                    begin
                        rx_wr        = 1'b1;
                        rx_head_next = rx_head_inc;
                        rx_cnt_next  = rx_cnt_reg + udrb_pkg::RX_CW'(1);
                    end
                    else
                    begin
                        status_next = udrb_pkg::ST_RX_DROP;
                    end
                end
                udrb_pkg::OP_TXRDY:
                begin
                    if (tx_cnt_reg == '0)
                    begin
                        status_next = udrb_pkg::ST_TX_IDLE;
                    end
                    else
                    begin
                        tx_pop       = 1'b1;
                        tx_tail_next = tx_tail_inc;
                        tx_cnt_next  = tx_cnt_reg - udrb_pkg::TX_CW'(1);
                    end
                end
                udrb_pkg::OP_CLEAR:
                begin
                    cr_next = 1'b0;
                    lf_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register valid: set on execute, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            tx_cnt_reg    <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            rx_cnt_reg    <= '0;
            cr_reg        <= 1'b0;
            lf_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            tx_cnt_reg    <= tx_cnt_next;
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            rx_cnt_reg    <= rx_cnt_next;
            cr_reg        <= cr_next;
            lf_reg        <= lf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Ring stores and result payload
    always_ff @(posedge clk)
    begin
        if (tx_wr)
        begin
            tx_mem[tx_head_reg] <= tx_wr_echo ? rx_mem[rx_tail_reg] : q_item.data;
        end
        if (rx_wr)
        begin
            rx_mem[rx_head_reg] <= q_item.data;
        end
        if (go)
        begin
            status_reg    <= status_next;
            read_byte_reg <= get_ok ? rx_mem[rx_tail_reg] : '0;
            tx_valid_reg  <= tx_pop;
            tx_byte_reg   <= tx_pop ? tx_mem[tx_tail_reg] : '0;
            lost_reg      <= lost_next;
            rx_fill_reg   <= udrb_pkg::FILL_W'(rx_cnt_next);
            tx_fill_reg   <= udrb_pkg::FILL_W'(tx_cnt_next);
            cr_seen_reg   <= cr_next;
            lf_seen_reg   <= lf_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_item.status    = status_reg;
    assign out_item.read_byte = read_byte_reg;
    assign out_item.tx_valid  = tx_valid_reg;
    assign out_item.tx_byte   = tx_byte_reg;
    assign out_item.echo_lost = lost_reg;
    assign out_item.rx_fill   = rx_fill_reg;
    assign out_item.tx_fill   = tx_fill_reg;
    assign out_item.cr_seen   = cr_seen_reg;
    assign out_item.lf_seen   = lf_seen_reg;

endmodule

`default_nettype wire

>>> design/uart_dual_ring_buffer.sv
// UART transmit and receive rings behind one command channel.
// Input channel (in_valid / in_stall / in_item): one command per item,
// host put, host get, line received byte, transmitter ready, or clear
// of the sticky CR/LF flags. Each item yields exactly one result item
// on the output channel (out_valid / out_stall / out_item) carrying
// status, the byte read, the byte sent to the line, echo loss, both
// fill levels and the sticky flags after the command.
// The taken item is written into the two-entry command queue; execute
// runs on the queue head and loads the result register unless out_stall
// holds a pending result there.
// Throughput: one item per cycle while out_stall is low; execute updates
// both rings together, so the next command sees the updated pointers.
// While out_stall is high the result holds, the queue fills, and after
// two more items in_stall rises.
// Configuration (cfg_valid / cfg_ready / cfg_data): writes echo_enable,
// always ready; write it only while no item is in flight.
// Reset empties both rings, clears the flags and echo_enable; ring
// contents are not cleared and carry no valid bits.
`default_nettype none

module uart_dual_ring_buffer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire udrb_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output udrb_pkg::out_item_t      out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    logic               echo_reg;
    logic               q_valid;
    logic               q_pop;
    udrb_pkg::op_item_t q_item;

    // Echo enable register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            echo_reg <= cfg_data;
        end
    end

    udrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    udrb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo_en   (echo_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Transmit fill never passes the ring depth
    a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.tx_fill <= udrb_pkg::FILL_W'(udrb_pkg::TX_DEPTH)))
        else $error("transmit fill above ring depth");

    // Receive ring keeps one slot unused
    a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.rx_fill < udrb_pkg::FILL_W'(udrb_pkg::RX_DEPTH)))
        else $error("receive fill reached ring depth");

    // A byte sent to the line always reports ok
    a_tx_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.tx_valid) |-> (out_item.status == udrb_pkg::ST_OK))
        else $error("line byte sent with error status");

    // Echo is lost only with the transmit ring full
    a_echo_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.echo_lost) |->
            (out_item.tx_fill == udrb_pkg::FILL_W'(udrb_pkg::TX_DEPTH)))
        else $error("echo lost with room in transmit ring");

endmodule

`default_nettype wire
